// ----- hdl/adsmu_pkg.sv -----
// Shared codes and helpers for the DSP saturate / multiply unit.
// No dependencies; imported by arm_dsp_saturate_multiply_unit.
package adsmu_pkg;

    localparam int WORD_W = 32;
    localparam int HALF_W = 16;
    localparam int PROD_W = WORD_W + HALF_W;

    localparam logic [2:0] CMD_QADD  = 3'd0;
    localparam logic [2:0] CMD_QSUB  = 3'd1;
    localparam logic [2:0] CMD_QDADD = 3'd2;
    localparam logic [2:0] CMD_QDSUB = 3'd3;
    localparam logic [2:0] CMD_SMLA  = 3'd4;
    localparam logic [2:0] CMD_SMLAW = 3'd5;
    localparam logic [2:0] CMD_SMLAL = 3'd6;
    localparam logic [2:0] CMD_SMUL  = 3'd7;

    localparam logic [WORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

    // signed halfword pick, hi = 1 takes bits 31..16
    function automatic logic signed [HALF_W-1:0] f_half(input logic [WORD_W-1:0] v,
                                                        input logic hi);
        logic [HALF_W-1:0] h;
        h = hi ? v[WORD_W-1:HALF_W] : v[HALF_W-1:0];
        return signed'(h);
    endfunction

endpackage

// ----- hdl/arm_dsp_saturate_multiply_unit.sv -----
// DSP extension execute unit: QADD/QSUB/QDADD/QDSUB and the SMLA/SMUL family.
// Depends on adsmu_pkg (codes, saturation limits, halfword select).
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+------------------------------------------------
//  in      | i_valid | o_stall | i_cmd i_sel_x i_sel_y i_opnd_a i_opnd_b
//          |         |         | i_acc_low i_acc_high
//  out     | o_valid | i_stall | o_result_low o_result_high o_writes_high o_sets_q
//
// Three register stages: operand select / doubling, 32x16 multiply and saturating
// add, accumulate into the output register. One transfer per cycle sustained while
// i_stall is low. Each stage advances when the one after it is empty or moving,
// so bubbles close up and a stalled output holds. Reset is synchronous, active low,
// and clears only the stage valid bits.
module arm_dsp_saturate_multiply_unit
    import adsmu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_cmd,
    input  logic                     i_sel_x,
    input  logic                     i_sel_y,
    input  logic signed [WORD_W-1:0] i_opnd_a,
    input  logic signed [WORD_W-1:0] i_opnd_b,
    input  logic [WORD_W-1:0]        i_acc_low,
    input  logic [WORD_W-1:0]        i_acc_high,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [WORD_W-1:0]        o_result_low,
    output logic [WORD_W-1:0]        o_result_high,
    output logic                     o_writes_high,
    output logic                     o_sets_q
);

    logic rdy1, rdy2, rdy3;

    // stage 1
    logic                     r_s1_v;
    logic [2:0]               r_s1_cmd;
    logic                     r_s1_sx;
    logic [WORD_W-1:0]        r_s1_n;
    logic [WORD_W-1:0]        r_s1_b;
    logic                     r_s1_qd;
    logic signed [WORD_W-1:0] r_s1_mx;
    logic signed [HALF_W-1:0] r_s1_my;
    logic [WORD_W-1:0]        r_s1_alo;
    logic [WORD_W-1:0]        r_s1_ahi;

    // stage 2
    logic                     r_s2_v;
    logic [2:0]               r_s2_cmd;
    logic                     r_s2_sx;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic [WORD_W-1:0]        r_s2_sat;
    logic                     r_s2_q;
    logic [WORD_W-1:0]        r_s2_alo;
    logic [WORD_W-1:0]        r_s2_ahi;

    // stage 3 / output
    logic                     r_s3_v;
    logic [WORD_W-1:0]        r_s3_lo;
    logic [WORD_W-1:0]        r_s3_hi;
    logic                     r_s3_wh;
    logic                     r_s3_q;

    assign rdy3    = !r_s3_v || !i_stall;
    assign rdy2    = !r_s2_v || rdy3;
    assign rdy1    = !r_s1_v || rdy2;
    assign o_stall = !rdy1;

    // ---------------- stage 1: doubling and multiplier operands
    logic                     s1_dbl;
    logic                     s1_dov;
    logic [WORD_W-1:0]        n_s1_n;
    logic signed [WORD_W-1:0] n_s1_mx;
    logic signed [HALF_W-1:0] s1_hb;

    always_comb begin
        s1_dbl = (i_cmd == CMD_QDADD) || (i_cmd == CMD_QDSUB);
        // 2a overflows when the top two bits differ
        s1_dov = i_opnd_a[WORD_W-1] ^ i_opnd_a[WORD_W-2];
        if (!s1_dbl) begin
            n_s1_n = i_opnd_a;
        end else if (s1_dov) begin
            n_s1_n = i_opnd_a[WORD_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            n_s1_n = {i_opnd_a[WORD_W-2:0], 1'b0};
        end
        s1_hb = f_half(i_opnd_b, i_sel_x);
        if (i_cmd == CMD_SMLAW) begin
            n_s1_mx = i_opnd_b;
        end else begin
            n_s1_mx = WORD_W'(s1_hb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (rdy1) begin
            r_s1_v <= i_valid;
        end
        if (rdy1 && i_valid) begin
            r_s1_cmd <= i_cmd;
            r_s1_sx  <= i_sel_x;
            r_s1_n   <= n_s1_n;
            r_s1_b   <= i_opnd_b;
            r_s1_qd  <= s1_dbl && s1_dov;
            r_s1_mx  <= n_s1_mx;
            r_s1_my  <= f_half(i_opnd_a, i_sel_y);
            r_s1_alo <= i_acc_low;
            r_s1_ahi <= i_acc_high;
        end
    end

    // ---------------- stage 2: multiply, saturating add/sub
    logic                     s2_sub;
    logic signed [WORD_W:0]   s2_sum;
    logic [WORD_W-1:0]        n_s2_sat;
    logic                     s2_ov;
    logic signed [PROD_W-1:0] n_s2_prod;

    always_comb begin
        s2_sub = (r_s1_cmd == CMD_QSUB) || (r_s1_cmd == CMD_QDSUB);
        if (s2_sub) begin
            s2_sum = $signed({r_s1_b[WORD_W-1], r_s1_b})
                   - $signed({r_s1_n[WORD_W-1], r_s1_n});
        end else begin
            s2_sum = $signed({r_s1_b[WORD_W-1], r_s1_b})
                   + $signed({r_s1_n[WORD_W-1], r_s1_n});
        end
        s2_ov = s2_sum[WORD_W] ^ s2_sum[WORD_W-1];
        if (s2_ov) begin
            n_s2_sat = s2_sum[WORD_W] ? SAT_MIN : SAT_MAX;
        end else begin
            n_s2_sat = s2_sum[WORD_W-1:0];
        end
        n_s2_prod = PROD_W'(r_s1_mx) * PROD_W'(r_s1_my);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (rdy2) begin
            r_s2_v <= r_s1_v;
        end
        if (rdy2 && r_s1_v) begin
            r_s2_cmd  <= r_s1_cmd;
            r_s2_sx   <= r_s1_sx;
            r_s2_prod <= n_s2_prod;
            r_s2_sat  <= n_s2_sat;
            r_s2_q    <= r_s1_qd || s2_ov;
            r_s2_alo  <= r_s1_alo;
            r_s2_ahi  <= r_s1_ahi;
        end
    end

    // ---------------- stage 3: accumulate
    logic [WORD_W-1:0]     s3_acc_src;
    logic signed [WORD_W:0] s3_acc;
    logic [2*WORD_W-1:0]   s3_long;
    logic [WORD_W-1:0]     n_s3_lo;
    logic [WORD_W-1:0]     n_s3_hi;
    logic                  n_s3_wh;
    logic                  n_s3_q;

    always_comb begin
        // SMLAW takes bits 47..16 of the product (added unless sel_x), SMLA the 32-bit 16x16 product
        s3_acc_src = (r_s2_cmd == CMD_SMLAW) ? r_s2_prod[PROD_W-1:HALF_W]
                                             : r_s2_prod[WORD_W-1:0];
        s3_acc     = $signed({s3_acc_src[WORD_W-1], s3_acc_src})
                   + $signed({r_s2_alo[WORD_W-1], r_s2_alo});
        s3_long    = {r_s2_ahi, r_s2_alo}
                   + {{WORD_W{r_s2_prod[WORD_W-1]}}, r_s2_prod[WORD_W-1:0]};
        n_s3_lo = '0;
        n_s3_hi = '0;
        n_s3_wh = 1'b0;
        n_s3_q  = 1'b0;
        case (r_s2_cmd)
            CMD_QADD, CMD_QSUB, CMD_QDADD, CMD_QDSUB: begin
                n_s3_lo = r_s2_sat;
                n_s3_q  = r_s2_q;
            end
            CMD_SMLA: begin
                n_s3_lo = s3_acc[WORD_W-1:0];
                n_s3_q  = s3_acc[WORD_W] ^ s3_acc[WORD_W-1];
            end
            CMD_SMLAW: begin
                if (r_s2_sx) begin
                    n_s3_lo = s3_acc_src;
                end else begin
                    n_s3_lo = s3_acc[WORD_W-1:0];
                    n_s3_q  = s3_acc[WORD_W] ^ s3_acc[WORD_W-1];
                end
            end
            CMD_SMLAL: begin
                n_s3_lo = s3_long[WORD_W-1:0];
                n_s3_hi = s3_long[2*WORD_W-1:WORD_W];
                n_s3_wh = 1'b1;
            end
            CMD_SMUL: begin
                n_s3_lo = r_s2_prod[WORD_W-1:0];
            end
            default: begin
                n_s3_lo = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (rdy3) begin
            r_s3_v <= r_s2_v;
        end
        if (rdy3 && r_s2_v) begin
            r_s3_lo <= n_s3_lo;
            r_s3_hi <= n_s3_hi;
            r_s3_wh <= n_s3_wh;
            r_s3_q  <= n_s3_q;
        end
    end

    assign o_valid       = r_s3_v;
    assign o_result_low  = r_s3_lo;
    assign o_result_high = r_s3_hi;
    assign o_writes_high = r_s3_wh;
    assign o_sets_q      = r_s3_q;

`ifndef NO_ASSERTIONS
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_writes_high) |-> (o_result_high == '0))
        else $error("high word set without second destination");

    a_long_no_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_writes_high) |-> !o_sets_q)
        else $error("64-bit accumulate reported Q");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && !rdy3) |=> (r_s2_v && $stable(r_s2_prod) && $stable(r_s2_cmd)))
        else $error("stage 2 lost or changed while blocked");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !rdy2) |=> (r_s1_v && $stable(r_s1_n) && $stable(r_s1_mx)))
        else $error("stage 1 lost or changed while blocked");
`endif

endmodule
